// ===== hdl/amgf_pkg.sv =====
// ----------------------------------------------------------------------------
// amgf_pkg: shared types and constants
// Transaction payloads, calibration bundle, status codes and register map
// for the ADC median glitch filter.
// ----------------------------------------------------------------------------
package amgf_pkg;

    // Fixed field widths
    localparam int SAMPLE_BITS   = 12;
    localparam int CHAN_BITS     = 6;
    localparam int SLOPE_BITS    = 20;
    localparam int TEMP_BITS     = 16;
    localparam int STATUS_BITS   = 3;
    localparam int CFG_ADDR_BITS = 5;
    localparam int CFG_DATA_BITS = 32;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] ST_FILTERED   = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_UNFILTERED = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_SAMPLES = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_DOWN       = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_RAW_ZERO   = 3'd4;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_AIR_CHANNEL     = 3'd0;
    localparam logic [2:0] REG_SURFACE_CHANNEL = 3'd1;
    localparam logic [2:0] REG_AIR_SLOPE       = 3'd2;
    localparam logic [2:0] REG_AIR_OFFSET      = 3'd3;
    localparam logic [2:0] REG_SURFACE_SLOPE   = 3'd4;
    localparam logic [2:0] REG_SURFACE_OFFSET  = 3'd5;
    localparam logic [2:0] REG_DEFAULT_SLOPE   = 3'd6;
    localparam logic [2:0] REG_DEFAULT_OFFSET  = 3'd7;

    // Input transaction
    typedef struct packed {
        logic [CHAN_BITS-1:0]   channel;
        logic [SAMPLE_BITS-1:0] raw_sample;
    } sample_t;

    // Output transaction
    typedef struct packed {
        logic [STATUS_BITS-1:0]      status;
        logic signed [TEMP_BITS-1:0] temperature;
        logic [SAMPLE_BITS-1:0]      median_count;
    } result_t;

    // Calibration registers as one bundle
    typedef struct packed {
        logic [CHAN_BITS-1:0]        air_channel;
        logic [CHAN_BITS-1:0]        surface_channel;
        logic [SLOPE_BITS-1:0]       air_slope;
        logic signed [TEMP_BITS-1:0] air_offset;
        logic [SLOPE_BITS-1:0]       surface_slope;
        logic signed [TEMP_BITS-1:0] surface_offset;
        logic [SLOPE_BITS-1:0]       default_slope;
        logic signed [TEMP_BITS-1:0] default_offset;
    } cal_t;

endpackage

// ===== hdl/amgf_ram.sv =====
// ----------------------------------------------------------------------------
// amgf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module amgf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/amgf_regs.sv =====
// ----------------------------------------------------------------------------
// amgf_regs: calibration register file
// APB-style slave holding probe channel numbers, slopes and offsets.
// ----------------------------------------------------------------------------
module amgf_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [amgf_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [amgf_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [amgf_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output amgf_pkg::cal_t                      cal
);

    amgf_pkg::cal_t cal_reg;
    logic [2:0]     index;
    logic           wr_en;

    assign index  = paddr[amgf_pkg::CFG_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg.air_channel     <= 6'd0;
            cal_reg.surface_channel <= 6'd1;
            cal_reg.air_slope       <= 20'd1724;
            cal_reg.air_offset      <= -16'sd16512;
            cal_reg.surface_slope   <= 20'd1724;
            cal_reg.surface_offset  <= -16'sd16512;
            cal_reg.default_slope   <= 20'd1724;
            cal_reg.default_offset  <= -16'sd16512;
        end
        else if (wr_en)
        begin
            unique case (index)
                amgf_pkg::REG_AIR_CHANNEL:
                    cal_reg.air_channel <= pwdata[amgf_pkg::CHAN_BITS-1:0];
                amgf_pkg::REG_SURFACE_CHANNEL:
                    cal_reg.surface_channel <= pwdata[amgf_pkg::CHAN_BITS-1:0];
                amgf_pkg::REG_AIR_SLOPE:
                    cal_reg.air_slope <= pwdata[amgf_pkg::SLOPE_BITS-1:0];
                amgf_pkg::REG_AIR_OFFSET:
                    cal_reg.air_offset <= pwdata[amgf_pkg::TEMP_BITS-1:0];
                amgf_pkg::REG_SURFACE_SLOPE:
                    cal_reg.surface_slope <= pwdata[amgf_pkg::SLOPE_BITS-1:0];
                amgf_pkg::REG_SURFACE_OFFSET:
                    cal_reg.surface_offset <= pwdata[amgf_pkg::TEMP_BITS-1:0];
                amgf_pkg::REG_DEFAULT_SLOPE:
                    cal_reg.default_slope <= pwdata[amgf_pkg::SLOPE_BITS-1:0];
                amgf_pkg::REG_DEFAULT_OFFSET:
                    cal_reg.default_offset <= pwdata[amgf_pkg::TEMP_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    // Read-back, zero extended
    always_comb
    begin
        prdata = '0;
        unique case (index)
            amgf_pkg::REG_AIR_CHANNEL:
                prdata = 32'(cal_reg.air_channel);
            amgf_pkg::REG_SURFACE_CHANNEL:
                prdata = 32'(cal_reg.surface_channel);
            amgf_pkg::REG_AIR_SLOPE:
                prdata = 32'(cal_reg.air_slope);
            amgf_pkg::REG_AIR_OFFSET:
                prdata = 32'(unsigned'(cal_reg.air_offset));
            amgf_pkg::REG_SURFACE_SLOPE:
                prdata = 32'(cal_reg.surface_slope);
            amgf_pkg::REG_SURFACE_OFFSET:
                prdata = 32'(unsigned'(cal_reg.surface_offset));
            amgf_pkg::REG_DEFAULT_SLOPE:
                prdata = 32'(cal_reg.default_slope);
            amgf_pkg::REG_DEFAULT_OFFSET:
                prdata = 32'(unsigned'(cal_reg.default_offset));
            default:
                prdata = '0;
        endcase
    end

endmodule

// ===== hdl/amgf_median.sv =====
// ----------------------------------------------------------------------------
// amgf_median: insertion sorter
// Takes one window sample per cycle into an ascending register list and
// offers one sorted entry at a chosen index.
// ----------------------------------------------------------------------------
module amgf_median #(
    parameter int DEPTH = 7,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              insert,
    input  logic [amgf_pkg::SAMPLE_BITS-1:0]  insert_data,
    input  logic [IW-1:0]                     pick_idx,
    output logic [amgf_pkg::SAMPLE_BITS-1:0]  pick_data
);

    logic [amgf_pkg::SAMPLE_BITS-1:0] sorted_reg  [DEPTH];
    logic [amgf_pkg::SAMPLE_BITS-1:0] sorted_next [DEPTH];
    logic [CW-1:0]                    fill_reg;
    logic [DEPTH-1:0]                 below;

    // Entries not above the new value stay; the rest shift up by one
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            below[i] = (CW'(i) < fill_reg) && (sorted_reg[i] <= insert_data);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            if (below[i])
            begin
                sorted_next[i] = sorted_reg[i];
            end
            else if (i > 0 && !below[(i > 0) ? i - 1 : 0])
            begin
                sorted_next[i] = sorted_reg[(i > 0) ? i - 1 : 0];
            end
            else
            begin
                sorted_next[i] = insert_data;
            end
        end
    end

    // Occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (clear)
        begin
            fill_reg <= '0;
        end
        else if (insert && fill_reg < CW'(DEPTH))
        begin
            fill_reg <= fill_reg + 1'b1;
        end
    end

    // Sorted list
    always_ff @(posedge clk)
    begin
        if (insert && !clear)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                sorted_reg[i] <= sorted_next[i];
            end
        end
    end

    assign pick_data = sorted_reg[pick_idx];

`ifndef SYNTH
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("sorter holds more entries than the window");
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> fill_reg == '0)
        else $error("sorter not empty after clear");
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (insert && !clear && fill_reg < CW'(DEPTH)) |=> fill_reg == $past(fill_reg) + 1'b1)
        else $error("sorter occupancy did not advance on insert");
`endif

endmodule

// ===== hdl/amgf_scale.sv =====
// ----------------------------------------------------------------------------
// amgf_scale: count to temperature conversion
// Picks the channel calibration, multiplies by the Q4.16 slope, rounds to
// Q8.8, adds the offset and saturates. Two pipeline stages.
// ----------------------------------------------------------------------------
module amgf_scale (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [amgf_pkg::CHAN_BITS-1:0]    channel,
    input  logic [amgf_pkg::SAMPLE_BITS-1:0]  count,
    input  amgf_pkg::cal_t                    cal,
    output logic                              done,
    output logic signed [amgf_pkg::TEMP_BITS-1:0] temperature
);

    localparam int PB = amgf_pkg::SAMPLE_BITS + amgf_pkg::SLOPE_BITS;
    localparam int SB = PB - 8 + 2;

    logic [amgf_pkg::SLOPE_BITS-1:0]       slope;
    logic signed [amgf_pkg::TEMP_BITS-1:0] offset;
    logic [PB-1:0]                         prod_reg;
    logic signed [amgf_pkg::TEMP_BITS-1:0] offset_reg;
    logic                                  stage1_reg;
    logic                                  done_reg;
    logic signed [amgf_pkg::TEMP_BITS-1:0] temp_reg;
    logic [PB:0]                           rounded;
    logic signed [SB-1:0]                  sum;
    logic signed [amgf_pkg::TEMP_BITS-1:0] sat;

    // Calibration select: air wins over surface
    always_comb
    begin
        if (channel == cal.air_channel)
        begin
            slope  = cal.air_slope;
            offset = cal.air_offset;
        end
        else if (channel == cal.surface_channel)
        begin
            slope  = cal.surface_slope;
            offset = cal.surface_offset;
        end
        else
        begin
            slope  = cal.default_slope;
            offset = cal.default_offset;
        end
    end

    // Round half up to Q8.8, add offset, clamp
    always_comb
    begin
        rounded = {1'b0, prod_reg} + (PB + 1)'(128);
        sum     = signed'({1'b0, rounded[PB:8]}) + SB'(offset_reg);
        if (sum > SB'(32767))
        begin
            sat = 16'sh7FFF;
        end
        else if (sum < -SB'(32768))
        begin
            sat = -16'sh8000;
        end
        else
        begin
            sat = sum[amgf_pkg::TEMP_BITS-1:0];
        end
    end

    // Control pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            stage1_reg <= start;
            done_reg   <= stage1_reg;
        end
    end

    // Data pipeline
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg   <= PB'(count) * PB'(slope);
            offset_reg <= offset;
        end
        if (stage1_reg)
        begin
            temp_reg <= sat;
        end
    end

    assign done        = done_reg;
    assign temperature = temp_reg;

endmodule

// ===== hdl/adc_median_glitch_filter.sv =====
// ----------------------------------------------------------------------------
// adc_median_glitch_filter: per-channel median filter with temperature scaling
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+---------------------
//   sample    | in        | sample_valid/ready    | amgf_pkg::sample_t
//   result    | out       | result_valid/ready    | amgf_pkg::result_t
//   config    | in        | APB psel/penable      | calibration regs
//
// One transaction at a time. A sample ending in a sorted window goes through
// lookup, metadata read, one window read per stored sample, last sorter insert,
// two median picks, scaler wait, output and idle before the next is taken.
// Others go from lookup or metadata read to output (direct ones via the scaler).
// A waiting result does not block the next sample; a stalled result holds the
// block in its output step. No clearing pass: slot flags mark live metadata.
// ----------------------------------------------------------------------------
module adc_median_glitch_filter #(
    parameter int WINDOW_DEPTH = 7,
    parameter int SLOT_COUNT   = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_ready,
    input  amgf_pkg::sample_t                  sample,
    output logic                               result_valid,
    input  logic                               result_ready,
    output amgf_pkg::result_t                  result,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [amgf_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [amgf_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [amgf_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    localparam int SMB = amgf_pkg::SAMPLE_BITS;
    localparam int PW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CW  = $clog2(WINDOW_DEPTH + 1);
    localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int MW  = PW + 2 * CW;
    localparam int WIN_DEPTH = SLOT_COUNT * WINDOW_DEPTH;
    localparam int AW  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_META,
        S_READ,
        S_LAST,
        S_PICK_HI,
        S_PICK_LO,
        S_SCALE,
        S_OUT
    } state_t;

    state_t                         state_reg, state_next;
    logic [amgf_pkg::CHAN_BITS-1:0] ch_reg, ch_next;
    logic [SMB-1:0]                 raw_reg, raw_next;
    logic [SW-1:0]                  slot_reg, slot_next;
    logic                           fresh_reg, fresh_next;
    logic [CW-1:0]                  n_reg, n_next;
    logic [PW-1:0]                  idx_reg, idx_next;
    logic                           rd_vld_reg, rd_vld_next;
    logic [SMB-1:0]                 hi_reg, hi_next;
    logic [SMB-1:0]                 cnt_reg, cnt_next;
    logic [amgf_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic                           conv_reg, conv_next;
    amgf_pkg::result_t              result_reg, result_next;
    logic                           result_valid_reg, result_valid_next;
    logic [SLOT_COUNT-1:0]          used_reg, used_next;
    logic [amgf_pkg::CHAN_BITS-1:0] chan_reg  [SLOT_COUNT];
    logic [amgf_pkg::CHAN_BITS-1:0] chan_next [SLOT_COUNT];

    // Slot lookup
    logic          hit, has_free;
    logic [SW-1:0] hit_idx, free_idx;

    // Memory ports
    logic           meta_re, meta_we;
    logic [SW-1:0]  meta_raddr;
    logic [MW-1:0]  meta_wdata, meta_rdata;
    logic           win_we, win_re;
    logic [AW-1:0]  win_waddr, win_raddr, win_base;
    logic [SMB-1:0] win_rdata;

    // Metadata fields of the slot in hand
    logic [PW-1:0] m_wp, wp_new;
    logic [CW-1:0] m_gc, m_fs, gc_new;
    logic [CW:0]   fs_inc;

    // Sorter, scaler
    logic           sort_clear;
    logic [PW-1:0]  pick_idx, mid_hi, mid_lo;
    logic [SMB-1:0] pick_data;
    logic [SMB:0]   pair_sum;
    logic           scale_start, scale_done;
    logic [SMB-1:0] scale_count;
    logic signed [amgf_pkg::TEMP_BITS-1:0] scale_temp;
    amgf_pkg::cal_t cal;

    amgf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    // Per-slot write position, good count and failure streak
    amgf_ram #(
        .WIDTH (MW),
        .DEPTH (SLOT_COUNT)
    ) u_meta_ram (
        .clk   (clk),
        .we    (meta_we),
        .waddr (slot_reg),
        .wdata (meta_wdata),
        .re    (meta_re),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    // Circular sample windows, WINDOW_DEPTH entries per slot
    amgf_ram #(
        .WIDTH (SMB),
        .DEPTH (WIN_DEPTH)
    ) u_win_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (raw_reg),
        .re    (win_re),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    amgf_median #(
        .DEPTH (WINDOW_DEPTH)
    ) u_median (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (sort_clear),
        .insert      (rd_vld_reg),
        .insert_data (win_rdata),
        .pick_idx    (pick_idx),
        .pick_data   (pick_data)
    );

    amgf_scale u_scale (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scale_start),
        .channel     (ch_reg),
        .count       (scale_count),
        .cal         (cal),
        .done        (scale_done),
        .temperature (scale_temp)
    );

    // Find the channel's slot, else the lowest free one
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        has_free = 1'b0;
        free_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (used_reg[i] && chan_reg[i] == ch_reg)
            begin
                hit     = 1'b1;
                hit_idx = SW'(i);
            end
            if (!used_reg[i])
            begin
                has_free = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // A newly claimed slot reads as all zero
    assign m_wp     = fresh_reg ? '0 : meta_rdata[PW-1:0];
    assign m_gc     = fresh_reg ? '0 : meta_rdata[PW+CW-1:PW];
    assign m_fs     = fresh_reg ? '0 : meta_rdata[MW-1:PW+CW];
    assign fs_inc   = {1'b0, m_fs} + 1'b1;
    assign wp_new   = (m_wp == PW'(WINDOW_DEPTH - 1)) ? '0 : m_wp + 1'b1;
    assign gc_new   = (m_gc < CW'(WINDOW_DEPTH)) ? m_gc + 1'b1 : m_gc;
    assign win_base = AW'(slot_reg) * AW'(WINDOW_DEPTH);

    // Median picks
    assign mid_hi   = PW'(n_reg >> 1);
    assign mid_lo   = n_reg[0] ? mid_hi : mid_hi - 1'b1;
    assign pick_idx = (state_reg == S_PICK_HI) ? mid_hi : mid_lo;
    assign pair_sum = {1'b0, hi_reg} + {1'b0, pick_data};

    // Sequencer next state
    always_comb
    begin
        state_next        = state_reg;
        ch_next           = ch_reg;
        raw_next          = raw_reg;
        slot_next         = slot_reg;
        fresh_next        = fresh_reg;
        n_next            = n_reg;
        idx_next          = idx_reg;
        rd_vld_next       = 1'b0;
        hi_next           = hi_reg;
        cnt_next          = cnt_reg;
        status_next       = status_reg;
        conv_next         = conv_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !result_ready;
        used_next         = used_reg;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            chan_next[i] = chan_reg[i];
        end
        meta_re     = 1'b0;
        meta_raddr  = hit ? hit_idx : free_idx;
        meta_we     = 1'b0;
        meta_wdata  = '0;
        win_we      = 1'b0;
        win_waddr   = win_base + AW'(m_wp);
        win_re      = 1'b0;
        win_raddr   = win_base + AW'(idx_reg);
        sort_clear  = 1'b0;
        scale_start = 1'b0;
        scale_count = raw_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    ch_next    = sample.channel;
                    raw_next   = sample.raw_sample;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                conv_next = 1'b0;
                cnt_next  = '0;
                if (hit || has_free)
                begin
                    slot_next  = meta_raddr;
                    fresh_next = !hit;
                    meta_re    = 1'b1;
                    if (!hit)
                    begin
                        used_next[free_idx] = 1'b1;
                        chan_next[free_idx] = ch_reg;
                    end
                    state_next = S_META;
                end
                else if (raw_reg == '0)
                begin
                    status_next = amgf_pkg::ST_RAW_ZERO;
                    state_next  = S_OUT;
                end
                else
                begin
                    status_next = amgf_pkg::ST_UNFILTERED;
                    conv_next   = 1'b1;
                    cnt_next    = raw_reg;
                    scale_start = 1'b1;
                    state_next  = S_SCALE;
                end
            end
            S_META:
            begin
                meta_we    = 1'b1;
                sort_clear = 1'b1;
                idx_next   = '0;
                if (raw_reg == '0 && fs_inc >= (CW + 1)'(WINDOW_DEPTH))
                begin
                    // Streak fills a window: empty it
                    meta_wdata  = {CW'(WINDOW_DEPTH), CW'(0), PW'(0)};
                    status_next = amgf_pkg::ST_DOWN;
                    state_next  = S_OUT;
                end
                else if (raw_reg == '0)
                begin
                    meta_wdata = {fs_inc[CW-1:0], m_gc, m_wp};
                    n_next     = m_gc;
                    if (m_gc == '0)
                    begin
                        status_next = amgf_pkg::ST_NO_SAMPLES;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
                else
                begin
                    win_we     = 1'b1;
                    meta_wdata = {CW'(0), gc_new, wp_new};
                    n_next     = gc_new;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                win_re      = 1'b1;
                rd_vld_next = 1'b1;
                if (CW'(idx_reg) == n_reg - 1'b1)
                begin
                    state_next = S_LAST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_LAST:
            begin
                state_next = S_PICK_HI;
            end
            S_PICK_HI:
            begin
                hi_next    = pick_data;
                state_next = S_PICK_LO;
            end
            S_PICK_LO:
            begin
                cnt_next    = n_reg[0] ? hi_reg : pair_sum[SMB:1];
                scale_count = cnt_next;
                scale_start = 1'b1;
                status_next = amgf_pkg::ST_FILTERED;
                conv_next   = 1'b1;
                state_next  = S_SCALE;
            end
            S_SCALE:
            begin
                if (scale_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.status       = status_reg;
                    result_next.temperature  = conv_reg ? scale_temp : '0;
                    result_next.median_count = cnt_reg;
                    result_valid_next        = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ch_reg           <= '0;
            raw_reg          <= '0;
            slot_reg         <= '0;
            fresh_reg        <= 1'b0;
            n_reg            <= '0;
            idx_reg          <= '0;
            rd_vld_reg       <= 1'b0;
            hi_reg           <= '0;
            cnt_reg          <= '0;
            status_reg       <= amgf_pkg::ST_FILTERED;
            conv_reg         <= 1'b0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
            used_reg         <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                chan_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            ch_reg           <= ch_next;
            raw_reg          <= raw_next;
            slot_reg         <= slot_next;
            fresh_reg        <= fresh_next;
            n_reg            <= n_next;
            idx_reg          <= idx_next;
            rd_vld_reg       <= rd_vld_next;
            hi_reg           <= hi_next;
            cnt_reg          <= cnt_next;
            status_reg       <= status_next;
            conv_reg         <= conv_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
            used_reg         <= used_next;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                chan_reg[i] <= chan_next[i];
            end
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTH
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && sample_ready) |=> !sample_ready)
        else $error("second sample taken while one is in flight");
    a_scale_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        scale_done |-> state_reg == S_SCALE)
        else $error("scaler finished outside its wait step");
    a_insert_in_sort: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> (state_reg == S_READ || state_reg == S_LAST))
        else $error("window read landed outside the sort steps");
    a_blank_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status == amgf_pkg::ST_NO_SAMPLES ||
            result.status == amgf_pkg::ST_DOWN ||
            result.status == amgf_pkg::ST_RAW_ZERO))
        |-> (result.temperature == '0 && result.median_count == '0))
        else $error("fields not cleared for a status without a reading");
`endif

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for adc_median_glitch_filter
// A table of directed samples covers slot claiming, the failure streak, the
// channel-down case, slot exhaustion and window wrap. Six calibration phases
// of mixed random traffic follow, with bursty input and stalled output.
// Each reading is checked against its typed row or a cycle-free filter model here.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_DEPTH = 7;
    localparam int SLOT_COUNT   = 4;
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 225;
    localparam int DRAIN_CYCLES = 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_LIMIT = 10;
    localparam int DIR_ROWS     = 22;

    // receiver stall style and sender gap ceiling for each phase
    localparam int STALL_BY_PHASE [PHASE_COUNT] = '{1, 0, 2, 3, 1, 2};
    localparam int GAP_BY_PHASE   [PHASE_COUNT] = '{6, 0, 10, 3, 0, 12};

    // channels that own the four slots after the directed part
    localparam logic [amgf_pkg::CHAN_BITS-1:0] TRACKED_CHANNELS [SLOT_COUNT] =
        '{6'd0, 6'd1, 6'd63, 6'd62};

    localparam amgf_pkg::cal_t RESET_CAL = '{
        air_channel:     6'd0,
        surface_channel: 6'd1,
        air_slope:       20'd1724,
        air_offset:      -16'sd16512,
        surface_slope:   20'd1724,
        surface_offset:  -16'sd16512,
        default_slope:   20'd1724,
        default_offset:  -16'sd16512
    };

    // directed row; want_status is only meaningful on typed rows
    typedef struct packed {
        logic [amgf_pkg::CHAN_BITS-1:0]   channel;
        logic [amgf_pkg::SAMPLE_BITS-1:0] raw;
        logic                             typed;
        logic [amgf_pkg::STATUS_BITS-1:0] want_status;
    } dir_row_t;

    dir_row_t directed_rows [DIR_ROWS] = '{
        // fresh slot, failed readings: nothing stored yet
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_NO_SAMPLES},
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_NO_SAMPLES},
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_NO_SAMPLES},
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_NO_SAMPLES},
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_NO_SAMPLES},
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_NO_SAMPLES},
        // streak hits the window depth: channel down, and stays down
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_DOWN},
        '{6'd0, 12'd0, 1'b1, amgf_pkg::ST_DOWN},
        // recovery at full scale, then claim the remaining slots
        '{6'd0, 12'd4095, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd1, 12'd1, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd63, 12'd2048, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd62, 12'd4095, 1'b0, amgf_pkg::ST_FILTERED},
        // no free slot left: direct conversion
        '{6'd5, 12'd0, 1'b1, amgf_pkg::ST_RAW_ZERO},
        '{6'd5, 12'd4095, 1'b0, amgf_pkg::ST_UNFILTERED},
        // fill channel 0 through even and odd counts and wrap the window
        '{6'd0, 12'd100, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd0, 12'd4095, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd0, 12'd1, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd0, 12'd2000, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd0, 12'd3000, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd0, 12'd7, 1'b0, amgf_pkg::ST_FILTERED},
        '{6'd0, 12'd50, 1'b0, amgf_pkg::ST_FILTERED},
        // failed reading with data already in the window
        '{6'd1, 12'd0, 1'b0, amgf_pkg::ST_FILTERED}
    };

    logic                               clk;
    logic                               rst_n = 1'b0;
    logic                               sample_valid = 1'b0;
    logic                               sample_ready;
    amgf_pkg::sample_t                  sample_data = '0;
    logic                               result_valid;
    logic                               result_ready = 1'b0;
    amgf_pkg::result_t                  result_data;
    logic                               psel = 1'b0;
    logic                               penable = 1'b0;
    logic                               pwrite = 1'b0;
    logic [amgf_pkg::CFG_ADDR_BITS-1:0] paddr = '0;
    logic [amgf_pkg::CFG_DATA_BITS-1:0] pwdata = '0;
    logic [amgf_pkg::CFG_DATA_BITS-1:0] prdata;
    logic                               pready;

    // filter model state
    amgf_pkg::cal_t                     calib = RESET_CAL;
    bit                                 slot_taken [SLOT_COUNT];
    logic [amgf_pkg::CHAN_BITS-1:0]     slot_owner [SLOT_COUNT];
    logic [amgf_pkg::SAMPLE_BITS-1:0]   window_mem [SLOT_COUNT][WINDOW_DEPTH];
    int                                 write_idx [SLOT_COUNT];
    int                                 stored [SLOT_COUNT];
    int                                 fail_run [SLOT_COUNT];

    amgf_pkg::result_t                  queued_readings [$];
    int                                 mismatches = 0;
    int                                 items_sent = 0;
    int                                 readings_checked = 0;
    int                                 status_seen [8];
    int                                 cycle_count = 0;
    int                                 stall_mode = 1;
    int                                 gap_max = 0;
    int                                 burst_left = 1;
    logic [15:0]                        ready_pattern = 16'b1011_0011_1000_1111;

    adc_median_glitch_filter #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SLOT_COUNT   (SLOT_COUNT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d readings outstanding",
                     cycle_count, queued_readings.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        case (stall_mode)
            0: result_ready <= 1'b1;
            1: result_ready <= 1'($urandom_range(0, 1));
            2:
            begin
                ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
                result_ready  <= ready_pattern[0];
            end
            default: result_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic note_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%s", msg);
    endtask

    // count * slope in Q.16, rounded to Q8.8, plus offset, saturated
    function automatic logic signed [amgf_pkg::TEMP_BITS-1:0] to_celsius(
        logic [amgf_pkg::SAMPLE_BITS-1:0] count, logic [amgf_pkg::CHAN_BITS-1:0] ch);
        logic [amgf_pkg::SLOPE_BITS-1:0]       slope;
        logic signed [amgf_pkg::TEMP_BITS-1:0] offset;
        longint                                t;
        if (ch == calib.air_channel)
        begin
            slope  = calib.air_slope;
            offset = calib.air_offset;
        end
        else if (ch == calib.surface_channel)
        begin
            slope  = calib.surface_slope;
            offset = calib.surface_offset;
        end
        else
        begin
            slope  = calib.default_slope;
            offset = calib.default_offset;
        end
        t = ((longint'(count) * longint'(slope) + 128) >>> 8) + longint'(offset);
        if (t > 32767)
            t = 32767;
        if (t < -32768)
            t = -32768;
        return t[amgf_pkg::TEMP_BITS-1:0];
    endfunction

    // median of the stored samples, floor average of the middle pair if even
    function automatic logic [amgf_pkg::SAMPLE_BITS-1:0] window_median(int slot);
        logic [amgf_pkg::SAMPLE_BITS-1:0] ordered [WINDOW_DEPTH];
        logic [amgf_pkg::SAMPLE_BITS-1:0] v;
        int                               n;
        int                               j;
        n = stored[slot];
        for (int i = 0; i < n; i++)
        begin
            v = window_mem[slot][i];
            j = i;
            while (j > 0 && ordered[j-1] > v)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        if (n % 2 == 1)
            return ordered[n/2];
        return amgf_pkg::SAMPLE_BITS'((int'(ordered[n/2-1]) + int'(ordered[n/2])) / 2);
    endfunction

    // advance the filter model by one sample and return its reading
    function automatic amgf_pkg::result_t filter_reading(amgf_pkg::sample_t item);
        amgf_pkg::result_t r;
        int                slot;
        r    = '0;
        slot = -1;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot < 0 && slot_taken[i] && slot_owner[i] == item.channel)
                slot = i;
        for (int i = 0; i < SLOT_COUNT; i++)
            if (slot < 0 && !slot_taken[i])
            begin
                slot_taken[i] = 1'b1;
                slot_owner[i] = item.channel;
                slot = i;
            end

        if (slot < 0)
        begin
            // no slot: convert the count directly
            if (item.raw_sample == 0)
                r.status = amgf_pkg::ST_RAW_ZERO;
            else
            begin
                r.status       = amgf_pkg::ST_UNFILTERED;
                r.median_count = item.raw_sample;
                r.temperature  = to_celsius(item.raw_sample, item.channel);
            end
        end
        else if (item.raw_sample == 0 && fail_run[slot] + 1 >= WINDOW_DEPTH)
        begin
            // streak fills the window: flush it
            fail_run[slot]  = WINDOW_DEPTH;
            stored[slot]    = 0;
            write_idx[slot] = 0;
            r.status        = amgf_pkg::ST_DOWN;
        end
        else
        begin
            if (item.raw_sample == 0)
                fail_run[slot]++;
            else
            begin
                fail_run[slot] = 0;
                window_mem[slot][write_idx[slot]] = item.raw_sample;
                write_idx[slot] = (write_idx[slot] + 1) % WINDOW_DEPTH;
                if (stored[slot] < WINDOW_DEPTH)
                    stored[slot]++;
            end
            if (stored[slot] == 0)
                r.status = amgf_pkg::ST_NO_SAMPLES;
            else
            begin
                r.status       = amgf_pkg::ST_FILTERED;
                r.median_count = window_median(slot);
                r.temperature  = to_celsius(r.median_count, item.channel);
            end
        end
        return r;
    endfunction

    // reading check
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (queued_readings.size() == 0)
                note_mismatch($sformatf(
                    "unexpected reading: status %0d temp %0d count %0d",
                    result_data.status, result_data.temperature,
                    result_data.median_count));
            else
            begin
                amgf_pkg::result_t want;
                want = queued_readings.pop_front();
                readings_checked++;
                status_seen[result_data.status]++;
                if (result_data.status !== want.status
                    || result_data.temperature !== want.temperature
                    || result_data.median_count !== want.median_count)
                    note_mismatch($sformatf(
                        {"reading %0d: expected st %0d temp %0d cnt %0d,",
                         " got st %0d temp %0d cnt %0d"},
                        readings_checked, want.status, want.temperature,
                        want.median_count, result_data.status,
                        result_data.temperature, result_data.median_count));
            end
        end
    end

    // one sample transaction; typed rows carry their own expected status
    task automatic send_reading(amgf_pkg::sample_t item, logic typed,
                                logic [amgf_pkg::STATUS_BITS-1:0] typed_status);
        amgf_pkg::result_t predicted;
        int                gap;
        @(negedge clk);
        sample_data  = item;
        sample_valid = 1'b1;
        do
            @(posedge clk);
        while (!sample_ready);
        predicted = filter_reading(item);
        if (typed)
            predicted = '{status: typed_status, temperature: '0, median_count: '0};
        queued_readings.push_back(predicted);
        items_sent++;

        // sender bursts
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                sample_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // stop sending and wait for every outstanding reading
    task automatic settle_block();
        @(negedge clk);
        sample_valid = 1'b0;
        while (queued_readings.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic reg_matches(logic [2:0] idx,
                                         logic [amgf_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            amgf_pkg::REG_AIR_CHANNEL:
                return data[amgf_pkg::CHAN_BITS-1:0] === calib.air_channel;
            amgf_pkg::REG_SURFACE_CHANNEL:
                return data[amgf_pkg::CHAN_BITS-1:0] === calib.surface_channel;
            amgf_pkg::REG_AIR_SLOPE:
                return data[amgf_pkg::SLOPE_BITS-1:0] === calib.air_slope;
            amgf_pkg::REG_AIR_OFFSET:
                return data[amgf_pkg::TEMP_BITS-1:0] === calib.air_offset;
            amgf_pkg::REG_SURFACE_SLOPE:
                return data[amgf_pkg::SLOPE_BITS-1:0] === calib.surface_slope;
            amgf_pkg::REG_SURFACE_OFFSET:
                return data[amgf_pkg::TEMP_BITS-1:0] === calib.surface_offset;
            amgf_pkg::REG_DEFAULT_SLOPE:
                return data[amgf_pkg::SLOPE_BITS-1:0] === calib.default_slope;
            amgf_pkg::REG_DEFAULT_OFFSET:
                return data[amgf_pkg::TEMP_BITS-1:0] === calib.default_offset;
            default:
                return 1'b0;
        endcase
    endfunction

    // APB write, then read the register back
    task automatic write_reg(logic [2:0] idx, logic [amgf_pkg::CFG_DATA_BITS-1:0] data);
        logic [amgf_pkg::CFG_DATA_BITS-1:0] readback;
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            amgf_pkg::REG_AIR_CHANNEL:
                calib.air_channel = data[amgf_pkg::CHAN_BITS-1:0];
            amgf_pkg::REG_SURFACE_CHANNEL:
                calib.surface_channel = data[amgf_pkg::CHAN_BITS-1:0];
            amgf_pkg::REG_AIR_SLOPE:
                calib.air_slope = data[amgf_pkg::SLOPE_BITS-1:0];
            amgf_pkg::REG_AIR_OFFSET:
                calib.air_offset = data[amgf_pkg::TEMP_BITS-1:0];
            amgf_pkg::REG_SURFACE_SLOPE:
                calib.surface_slope = data[amgf_pkg::SLOPE_BITS-1:0];
            amgf_pkg::REG_SURFACE_OFFSET:
                calib.surface_offset = data[amgf_pkg::TEMP_BITS-1:0];
            amgf_pkg::REG_DEFAULT_SLOPE:
                calib.default_slope = data[amgf_pkg::SLOPE_BITS-1:0];
            amgf_pkg::REG_DEFAULT_OFFSET:
                calib.default_offset = data[amgf_pkg::TEMP_BITS-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;

        @(negedge clk);
        psel = 1'b1;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        readback = prdata;
        if (!reg_matches(idx, readback))
            note_mismatch($sformatf("register %0d read back 0x%08h after writing 0x%08h",
                                    idx, readback, data));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_calibration(amgf_pkg::cal_t c);
        write_reg(amgf_pkg::REG_AIR_CHANNEL,     32'(c.air_channel));
        write_reg(amgf_pkg::REG_SURFACE_CHANNEL, 32'(c.surface_channel));
        write_reg(amgf_pkg::REG_AIR_SLOPE,       32'(c.air_slope));
        write_reg(amgf_pkg::REG_AIR_OFFSET,      {16'h0000, c.air_offset});
        write_reg(amgf_pkg::REG_SURFACE_SLOPE,   32'(c.surface_slope));
        write_reg(amgf_pkg::REG_SURFACE_OFFSET,  {16'h0000, c.surface_offset});
        write_reg(amgf_pkg::REG_DEFAULT_SLOPE,   32'(c.default_slope));
        write_reg(amgf_pkg::REG_DEFAULT_OFFSET,  {16'h0000, c.default_offset});
    endtask

    function automatic logic [amgf_pkg::CHAN_BITS-1:0] pick_cal_channel();
        if ($urandom_range(0, 1) == 0)
            return TRACKED_CHANNELS[$urandom_range(0, SLOT_COUNT - 1)];
        return amgf_pkg::CHAN_BITS'($urandom_range(0, 63));
    endfunction

    function automatic amgf_pkg::cal_t rand_calibration();
        amgf_pkg::cal_t c;
        c.air_channel     = pick_cal_channel();
        c.surface_channel = pick_cal_channel();
        c.air_slope       = amgf_pkg::SLOPE_BITS'($urandom);
        c.air_offset      = amgf_pkg::TEMP_BITS'($urandom);
        c.surface_slope   = amgf_pkg::SLOPE_BITS'($urandom);
        c.surface_offset  = amgf_pkg::TEMP_BITS'($urandom);
        c.default_slope   = amgf_pkg::SLOPE_BITS'($urandom);
        c.default_offset  = amgf_pkg::TEMP_BITS'($urandom);
        return c;
    endfunction

    // ADC count with a given share of failed readings and extra weight on extremes
    function automatic logic [amgf_pkg::SAMPLE_BITS-1:0] rand_count(int zero_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < zero_pct)
            return '0;
        if (pick < zero_pct + 8)
            return 12'd4095;
        if (pick < zero_pct + 14)
            return 12'd1;
        if (pick < zero_pct + 24)
            return amgf_pkg::SAMPLE_BITS'($urandom_range(1, 31));
        return amgf_pkg::SAMPLE_BITS'($urandom_range(1, 4095));
    endfunction

    // mostly steady traffic on tracked channels, some failure runs, some noise
    task automatic run_random(int target);
        amgf_pkg::sample_t item;
        int                sent;
        int                mode;
        int                run_len;
        sent = 0;
        while (sent < target)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 65)
            begin
                item.channel    = TRACKED_CHANNELS[$urandom_range(0, SLOT_COUNT - 1)];
                item.raw_sample = rand_count(8);
                send_reading(item, 1'b0, amgf_pkg::ST_FILTERED);
                sent++;
            end
            else if (mode < 80)
            begin
                item.channel    = TRACKED_CHANNELS[$urandom_range(0, SLOT_COUNT - 1)];
                item.raw_sample = '0;
                run_len = $urandom_range(1, WINDOW_DEPTH + 3);
                repeat (run_len)
                begin
                    send_reading(item, 1'b0, amgf_pkg::ST_FILTERED);
                    sent++;
                end
            end
            else
            begin
                item.channel    = amgf_pkg::CHAN_BITS'($urandom_range(0, 63));
                item.raw_sample = rand_count(25);
                send_reading(item, 1'b0, amgf_pkg::ST_FILTERED);
                sent++;
            end
        end
    endtask

    initial
    begin
        amgf_pkg::cal_t    next_cal;
        amgf_pkg::sample_t item;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // directed table under reset calibration
        stall_mode = STALL_BY_PHASE[0];
        gap_max    = GAP_BY_PHASE[0];
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            item.channel    = directed_rows[r].channel;
            item.raw_sample = directed_rows[r].raw;
            send_reading(item, directed_rows[r].typed, directed_rows[r].want_status);
        end
        run_random(PHASE_ITEMS);

        for (int phase = 1; phase < PHASE_COUNT; phase++)
        begin
            settle_block();
            next_cal = rand_calibration();
            case (phase)
                1:
                begin
                    // top-range channels, full-scale slope, offset extremes
                    next_cal.air_channel     = 6'd63;
                    next_cal.surface_channel = 6'd62;
                    next_cal.air_slope       = 20'hFFFFF;
                    next_cal.air_offset      = 16'sh7FFF;
                    next_cal.surface_slope   = '0;
                    next_cal.surface_offset  = 16'sh8000;
                end
                2:
                begin
                    // both channel registers equal: air wins
                    next_cal.air_channel     = 6'd0;
                    next_cal.surface_channel = 6'd0;
                    next_cal.default_slope   = 20'hFFFFF;
                    next_cal.default_offset  = 16'sh8000;
                end
                5:
                begin
                    // realistic slopes so readings stay mostly unsaturated
                    next_cal.air_channel     = 6'd1;
                    next_cal.surface_channel = 6'd63;
                    next_cal.air_slope     = amgf_pkg::SLOPE_BITS'($urandom_range(0, 4000));
                    next_cal.surface_slope = amgf_pkg::SLOPE_BITS'($urandom_range(0, 4000));
                    next_cal.default_slope = amgf_pkg::SLOPE_BITS'($urandom_range(0, 4000));
                end
                default: ;
            endcase
            apply_calibration(next_cal);
            stall_mode = STALL_BY_PHASE[phase];
            gap_max    = GAP_BY_PHASE[phase];
            run_random(PHASE_ITEMS);
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("testbench: %0d samples over %0d calibration settings, %0d readings checked",
                 items_sent, PHASE_COUNT, readings_checked);
        $display({"testbench: filtered %0d, unfiltered %0d, no samples %0d,",
                  " down %0d, raw zero %0d, mismatches %0d"},
                 status_seen[amgf_pkg::ST_FILTERED], status_seen[amgf_pkg::ST_UNFILTERED],
                 status_seen[amgf_pkg::ST_NO_SAMPLES], status_seen[amgf_pkg::ST_DOWN],
                 status_seen[amgf_pkg::ST_RAW_ZERO], mismatches);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/amgf_pkg.sv
hdl/amgf_ram.sv
hdl/amgf_regs.sv
hdl/amgf_median.sv
hdl/amgf_scale.sv
hdl/adc_median_glitch_filter.sv
sim/testbench.sv
